// ===== rtl/core/touch_channel_peak_hold_filter_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the touch channel peak hold filter
// Shared macros so that every checker reports in the same way.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CHANNEL_PEAK_HOLD_FILTER_ASSERT_SVH
`define TOUCH_CHANNEL_PEAK_HOLD_FILTER_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define TCPHF_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("touch filter check failed");

// Antecedent implies consequent in the following cycle.
`define TCPHF_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("touch filter check failed");

`endif

// ===== rtl/core/tcphf_pkg.sv =====
// ----------------------------------------------------------------------------
// Touch channel peak hold filter package
// Sizes, constants, state codes and inter-module structs.
// ----------------------------------------------------------------------------
package tcphf_pkg;

   localparam int CHANNELS   = 16;
   localparam int RING_DEPTH = 8;
   localparam int CH_W       = $clog2(CHANNELS);
   localparam int PTR_W      = $clog2(RING_DEPTH);
   localparam int ADDR_W     = CH_W + PTR_W;
   localparam int DEPTH      = CHANNELS * RING_DEPTH;

   localparam int CHAN_W     = 4;
   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 7;
   localparam int ACT_W      = 5;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam int RUN_LIMIT  = 4;
   localparam int RUN_W      = 2;

   localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(50);
   localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(16);

   // Division by the percent scale is a multiply by a rounded-up reciprocal.
   localparam int    PERCENT     = 100;
   localparam int    PROD_W      = SAMPLE_W + RATE_W;
   localparam int    RECIP_SHIFT = 30;
   localparam int    RECIP_W     = 24;
   localparam int    HALF_W      = 17;
   localparam int    SCALED_W    = PROD_W + RECIP_W;
   localparam int    CMP_W       = HALF_W + 2;
   localparam longint RECIP_VAL  = ((64'sd1 <<< RECIP_SHIFT) + PERCENT - 1) / PERCENT;
   localparam logic [RECIP_W-1:0] RECIP_MULT = RECIP_W'(RECIP_VAL);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_RELEASE_RATE    = 1'b0,
      CSR_ACTIVE_CHANNELS = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_SCALE,
      ST_WINDOW,
      ST_FLUSH,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } fsm_state_type;

   typedef struct packed {
      logic                wr_en;
      logic [ADDR_W-1:0]   wr_addr;
      logic [SAMPLE_W-1:0] wr_data;
      logic                rd_en;
      logic [ADDR_W-1:0]   rd_addr;
   } ring_req_type;

   typedef struct packed {
      logic mul_en;
      logic scale_en;
   } win_ctl_type;

endpackage

// ===== rtl/core/touch_channel_peak_hold_filter.sv =====
// ----------------------------------------------------------------------------
// Touch channel peak hold filter
// Per-channel sliding-window maximum of touch samples with release flush.
// ----------------------------------------------------------------------------
// Usage. Each word on the req_ channel is one sample for one channel, with
// its detect flag, baseline and threshold. The block holds req_stall high
// while it works on a word and takes the next one only from idle. For a
// filtered channel the sample is written into that channel's ring of eight
// recent samples and the ring is scanned one entry a cycle through a single
// compare unit; that scan sets the latency. After four samples in the release
// window the ring is flushed instead (one memory write a cycle), and a
// sample that is not filtered passes straight through.
// The result word sits in an output register on the rsp_ channel; while
// rsp_stall is high it holds, and the next word may already be accepted and
// worked on, waiting at its end until the output register frees.
// The csr_ port is always ready; write it only while the block is idle.
// Reset is synchronous: rings read as zero, run counts and write pointers
// clear, release rate returns to 50 percent and all 16 channels are active.
// ----------------------------------------------------------------------------
module touch_channel_peak_hold_filter
   import tcphf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Input sample channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [CHAN_W-1:0]     req_channel,
   input  logic [SAMPLE_W-1:0]   req_sample,
   input  logic                  req_detected,
   input  logic [SAMPLE_W-1:0]   req_baseline,
   input  logic [SAMPLE_W-1:0]   req_threshold,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [CHAN_W-1:0]     rsp_out_channel,
   output logic [SAMPLE_W-1:0]   rsp_unfiltered,
   output logic [SAMPLE_W-1:0]   rsp_filtered,
   output logic                  rsp_ring_flushed,
   // Configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   fsm_state_type state_ff, state_in;

   // Captured word
   logic [CHAN_W-1:0]   chan_ff;
   logic [SAMPLE_W-1:0] sample_ff;
   logic                det_ff;
   logic [SAMPLE_W-1:0] base_ff;
   logic [SAMPLE_W-1:0] thr_ff;

   // Configuration
   logic [RATE_W-1:0]   rate_ff;
   logic [ACT_W-1:0]    active_ff;

   // Per-channel state
   logic [RUN_W-1:0]    run_ff [CHANNELS];
   logic [RUN_W-1:0]    run_in [CHANNELS];
   logic [PTR_W-1:0]    wp_ff  [CHANNELS];
   logic [PTR_W-1:0]    wp_in  [CHANNELS];

   // Sequencer datapath
   logic [PTR_W-1:0]    idx_ff, idx_in;
   logic [SAMPLE_W-1:0] max_ff, max_in;
   logic [SAMPLE_W-1:0] max_upd;
   logic                flushed_ff, flushed_in;
   logic                rd_pend_ff;
   logic                load_rsp;
   logic                filt_en;
   logic                in_window;
   logic [CH_W-1:0]     ch;
   logic [SAMPLE_W-1:0] rd_data;
   ring_req_type        ring_req;
   win_ctl_type         win_ctl;

   // Output register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAN_W-1:0]   rsp_chan_ff;
   logic [SAMPLE_W-1:0] rsp_unf_ff;
   logic [SAMPLE_W-1:0] rsp_filt_ff;
   logic                rsp_flush_ff;

   assign ch = chan_ff[CH_W-1:0];

   // A channel is filtered when the sample is detected and the channel lies
   // below both the programmed count and the number of rings built.
   assign filt_en = det_ff && ({1'b0, chan_ff} < active_ff)
                    && ({1'b0, chan_ff} < ACT_W'(CHANNELS));

   // The one shared compare unit that the ring scan runs through.
   assign max_upd = (rd_data > max_ff) ? rd_data : max_ff;

   tcphf_ring_mem u_ring_mem (
      .clock    (clock),
      .reset    (reset),
      .ring_req (ring_req),
      .rd_data  (rd_data)
   );

   tcphf_window u_window (
      .clock        (clock),
      .win_ctl      (win_ctl),
      .release_rate (rate_ff),
      .sample       (sample_ff),
      .baseline     (base_ff),
      .threshold    (thr_ff),
      .in_window    (in_window)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_stall  = 1'b1;
      ring_req   = '0;
      win_ctl    = '0;
      idx_in     = idx_ff;
      max_in     = rd_pend_ff ? max_upd : max_ff;
      flushed_in = flushed_ff;
      run_in     = run_ff;
      wp_in      = wp_ff;
      load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            win_ctl.mul_en = 1'b1;
            if (filt_en) begin
               state_in = ST_SCALE;
            end else begin
               // Pass-through: the run restarts and the ring is left alone.
               run_in[ch] = '0;
               flushed_in = 1'b0;
               max_in     = sample_ff;
               state_in   = ST_DONE;
            end
         end
         ST_SCALE: begin
            win_ctl.scale_en = 1'b1;
            state_in         = ST_WINDOW;
         end
         ST_WINDOW: begin
            ring_req.wr_en   = 1'b1;
            ring_req.wr_addr = {ch, wp_ff[ch]};
            ring_req.wr_data = sample_ff;
            wp_in[ch]        = wp_ff[ch] + 1'b1;
            idx_in           = '0;
            flushed_in       = 1'b0;
            max_in           = '0;
            state_in         = ST_SCAN;
            if (in_window) begin
               if (run_ff[ch] == RUN_W'(RUN_LIMIT - 1)) begin
                  // Run complete: the whole ring becomes this sample.
                  run_in[ch] = '0;
                  flushed_in = 1'b1;
                  max_in     = sample_ff;
                  state_in   = ST_FLUSH;
               end else begin
                  run_in[ch] = run_ff[ch] + 1'b1;
               end
            end else begin
               run_in[ch] = '0;
            end
         end
         ST_FLUSH: begin
            ring_req.wr_en   = 1'b1;
            ring_req.wr_addr = {ch, idx_ff};
            ring_req.wr_data = sample_ff;
            idx_in           = idx_ff + 1'b1;
            if (idx_ff == PTR_W'(RING_DEPTH - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = {ch, idx_ff};
            idx_in           = idx_ff + 1'b1;
            if (idx_ff == PTR_W'(RING_DEPTH - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // The last read word is folded into the maximum here.
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         chan_ff   <= req_channel;
         sample_ff <= req_sample;
         det_ff    <= req_detected;
         base_ff   <= req_baseline;
         thr_ff    <= req_threshold;
      end
      idx_ff     <= idx_in;
      max_ff     <= max_in;
      flushed_ff <= flushed_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff <= 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            run_ff[i] <= '0;
            wp_ff[i]  <= '0;
         end
      end else begin
         rd_pend_ff <= ring_req.rd_en;
         run_ff     <= run_in;
         wp_ff      <= wp_in;
      end
   end

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff   <= RATE_RESET;
         active_ff <= ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_RELEASE_RATE: begin
               rate_ff <= csr_data[RATE_W-1:0];
            end
            CSR_ACTIVE_CHANNELS: begin
               active_ff <= csr_data[ACT_W-1:0];
            end
         endcase
      end
   end

   // Output register: holds while the receiver stalls.
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_chan_ff  <= chan_ff;
         rsp_unf_ff   <= sample_ff;
         rsp_filt_ff  <= max_ff;
         rsp_flush_ff <= flushed_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_channel  = rsp_chan_ff;
   assign rsp_unfiltered   = rsp_unf_ff;
   assign rsp_filtered     = rsp_filt_ff;
   assign rsp_ring_flushed = rsp_flush_ff;

endmodule

// ===== rtl/core/tcphf_ring_mem.sv =====
// ----------------------------------------------------------------------------
// Sample ring memory
// One write and one registered read per cycle; entries read as zero until
// first written after reset.
// ----------------------------------------------------------------------------
module tcphf_ring_mem
   import tcphf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  ring_req_type        ring_req,
   output logic [SAMPLE_W-1:0] rd_data
);

   logic [SAMPLE_W-1:0] ring_ff [DEPTH];
   logic [DEPTH-1:0]    written_ff;
   logic [DEPTH-1:0]    written_in;
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic                rd_written_ff;

   always_ff @(posedge clock) begin
      if (ring_req.wr_en) begin
         ring_ff[ring_req.wr_addr] <= ring_req.wr_data;
      end
      if (ring_req.rd_en) begin
         rd_data_ff    <= ring_ff[ring_req.rd_addr];
         rd_written_ff <= written_ff[ring_req.rd_addr];
      end
   end

   always_comb begin
      written_in = written_ff;
      if (ring_req.wr_en) begin
         written_in[ring_req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

// ===== rtl/core/tcphf_window.sv =====
// ----------------------------------------------------------------------------
// Release window unit
// Works out the window half width over two multiply steps and compares the
// sample against it.
// ----------------------------------------------------------------------------
module tcphf_window
   import tcphf_pkg::*;
(
   input  logic                clock,
   input  win_ctl_type         win_ctl,
   input  logic [RATE_W-1:0]   release_rate,
   input  logic [SAMPLE_W-1:0] sample,
   input  logic [SAMPLE_W-1:0] baseline,
   input  logic [SAMPLE_W-1:0] threshold,
   output logic                in_window
);

   logic [PROD_W-1:0]       prod_ff;
   logic [PROD_W-1:0]       prod_in;
   logic [SCALED_W-1:0]     scaled;
   logic [HALF_W-1:0]       half_ff;
   logic signed [CMP_W-1:0] smp_val;
   logic signed [CMP_W-1:0] upper;
   logic signed [CMP_W-1:0] lower;

   assign prod_in = PROD_W'(threshold) * PROD_W'(release_rate);
   assign scaled  = SCALED_W'(prod_ff) * SCALED_W'(RECIP_MULT);

   always_ff @(posedge clock) begin
      if (win_ctl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (win_ctl.scale_en) begin
         half_ff <= scaled[RECIP_SHIFT +: HALF_W];
      end
   end

   // Bounds are exclusive and never wrap at this width.
   assign smp_val   = signed'(CMP_W'(sample));
   assign upper     = signed'(CMP_W'(baseline)) + signed'(CMP_W'(half_ff));
   assign lower     = signed'(CMP_W'(baseline)) - signed'(CMP_W'(half_ff));
   assign in_window = (smp_val < upper) && (smp_val > lower);

endmodule

// ===== rtl/core/tcphf_checker.sv =====
// ----------------------------------------------------------------------------
// Touch channel peak hold filter port checker
// Watches the top-level ports over time.
// ----------------------------------------------------------------------------
`include "touch_channel_peak_hold_filter_assert.svh"

module tcphf_checker
   import tcphf_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_stall,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic [SAMPLE_W-1:0]   rsp_unfiltered,
   input logic [SAMPLE_W-1:0]   rsp_filtered,
   input logic                  rsp_ring_flushed
);

   // One word at a time: taking a word closes the input at once.
   `TCPHF_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // A stalled result word holds.
   `TCPHF_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_filtered))

   // A flushed ring holds only the current sample.
   `TCPHF_ASSERT_NOW(a_flush_value, rsp_valid && rsp_ring_flushed, rsp_filtered == rsp_unfiltered)

   // The sample itself is in the ring, so the maximum never falls below it.
   `TCPHF_ASSERT_NOW(a_peak_floor, rsp_valid, rsp_filtered >= rsp_unfiltered)

endmodule

bind touch_channel_peak_hold_filter tcphf_checker u_tcphf_checker (.*);
